// File: rtl/tnc3_pkg.sv
// ---------------------------------------------------------------------------
// tnc3_pkg
// Shared widths, reset values and register codes of the 3x3 threshold
// noise cleaning unit.
// ---------------------------------------------------------------------------
package tnc3_pkg;

    localparam int DEF_MAX_WIDTH = 1024;

    localparam int PIX_W      = 8;
    localparam int THR_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int ROW_W      = 16;
    localparam int OUT_COL_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = PIX_W + 3;

    localparam logic [THR_W-1:0] THRESHOLD_RST    = 8'd32;
    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 16'd480;

    localparam int MIN_DIM = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD,
        CFG_FRAME_WIDTH,
        CFG_FRAME_HEIGHT
    } cfg_reg_t;

endpackage

// File: rtl/threshold_noise_cleaning_3x3_unit.sv
// ---------------------------------------------------------------------------
// threshold_noise_cleaning_3x3_unit
// Raster-order 3x3 impulse noise cleaner: the center pixel is replaced by
// the floor average of its eight neighbors when they differ by more than
// the threshold. Results are given for interior pixels only.
// ---------------------------------------------------------------------------
//
//  channel  | ports                                   | word
//  ---------+-----------------------------------------+------------------------
//  input    | s_valid s_ready s_pixel                 | one pixel, raster order
//  result   | m_valid m_ready m_out_row m_out_col     | one cleaned interior
//           | m_out_value m_replaced                  | pixel
//  config   | cfg_we cfg_addr cfg_wdata               | register write
//
//  one pixel per clock while the output register is free or being taken;
//  an accepted pixel and its line store read load the window stage, then
//  the new window and its neighbor average load the output register
//  both line rows share one RAM entry per column, read at accept and
//  written back when the word leaves the window stage
//  a stalled result holds the window stage; input keeps flowing while the
//  output register is free or being taken
//  reset clears positions, valids and configuration registers; line stores need no clear
//
module threshold_noise_cleaning_3x3_unit #(
    parameter int MAX_WIDTH = tnc3_pkg::DEF_MAX_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [tnc3_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [tnc3_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tnc3_pkg::PIX_W-1:0]       s_pixel,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tnc3_pkg::ROW_W-1:0]       m_out_row,
    output logic [tnc3_pkg::OUT_COL_W-1:0]   m_out_col,
    output logic [tnc3_pkg::PIX_W-1:0]       m_out_value,
    output logic                             m_replaced
);

    import tnc3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
    localparam int HW = FH_W + 1;

    // configuration
    logic [THR_W-1:0] thr_reg;
    logic [FW_W-1:0]  fw_reg;
    logic [FH_W-1:0]  fh_reg;

    // position counters
    logic [CW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // window stage
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_emit_reg;
    logic [PIX_W-1:0] win_reg  [9];
    logic [PIX_W-1:0] win_next [9];

    // result register
    logic                 m_valid_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic [PIX_W-1:0]     out_value_reg;
    logic                 replaced_reg;

    logic accept, out_free, s1_go;
    logic [2*PIX_W-1:0] line_rdata;
    logic [2*PIX_W-1:0] line_wdata;

    logic [EW-1:0] fw_ext, eff_w, col_inc;
    logic [HW-1:0] eff_h, row_inc;
    logic          col_wrap, row_wrap;

    logic [SUM_W-1:0] sum;
    logic [PIX_W-1:0] avg, center, diff;
    logic             rep;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_go    = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    // effective frame size, saturated
    always_comb begin
        fw_ext = EW'(fw_reg);
        if (fw_ext < EW'(MIN_DIM)) begin
            eff_w = EW'(MIN_DIM);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = fw_ext;
        end
        eff_h = (fh_reg < FH_W'(MIN_DIM)) ? HW'(MIN_DIM) : HW'(fh_reg);

        col_inc  = EW'(col_reg) + EW'(1);
        row_inc  = HW'(row_reg) + HW'(1);
        col_wrap = col_inc >= eff_w;
        row_wrap = row_inc >= eff_h;

        if (col_wrap) begin
            col_next = '0;
            row_next = row_wrap ? '0 : ROW_W'(row_inc);
        end else begin
            col_next = CW'(col_inc);
            row_next = row_reg;
        end
    end

    // line store entry: older row in the high byte, newer row in the low byte
    assign line_wdata = {line_rdata[PIX_W-1:0], s1_pixel_reg};

    tnc3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (s1_go),
        .waddr (s1_col_reg),
        .wdata (line_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (line_rdata)
    );

    // window shift and neighbor average
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[k*3]     = win_reg[k*3+1];
            win_next[k*3 + 1] = win_reg[k*3+2];
        end
        win_next[2] = line_rdata[2*PIX_W-1:PIX_W];
        win_next[5] = line_rdata[PIX_W-1:0];
        win_next[8] = s1_pixel_reg;

        sum = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                sum = sum + SUM_W'(win_next[k]);
            end
        end
        avg    = sum[SUM_W-1:3];
        center = win_next[4];
        diff   = (center > avg) ? center - avg : avg - center;
        rep    = diff > thr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESHOLD_RST;
            fw_reg  <= FRAME_WIDTH_RST;
            fh_reg  <= FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_THRESHOLD:    thr_reg <= cfg_wdata[THR_W-1:0];
                CFG_FRAME_WIDTH:  fw_reg  <= cfg_wdata[FW_W-1:0];
                CFG_FRAME_HEIGHT: fh_reg  <= cfg_wdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= s1_valid_reg && s1_emit_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pixel_reg <= s_pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_emit_reg  <= (row_reg >= ROW_W'(2)) && (col_reg >= CW'(2));
        end
        if (s1_go) begin
            win_reg <= win_next;
            if (s1_emit_reg) begin
                out_row_reg   <= s1_row_reg - ROW_W'(1);
                out_col_reg   <= OUT_COL_W'(s1_col_reg - CW'(1));
                out_value_reg <= rep ? avg : center;
                replaced_reg  <= rep;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_row   = out_row_reg;
    assign m_out_col   = out_col_reg;
    assign m_out_value = out_value_reg;
    assign m_replaced  = replaced_reg;

endmodule

// File: rtl/tnc3_ram.sv
// ---------------------------------------------------------------------------
// tnc3_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ---------------------------------------------------------------------------
module tnc3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/tnc3_checker.sv
// ---------------------------------------------------------------------------
// tnc3_checker
// Port-level checks of the 3x3 threshold noise cleaning unit, bound to
// the top level.
// ---------------------------------------------------------------------------
module tnc3_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [tnc3_pkg::ROW_W-1:0]       m_out_row,
    input logic [tnc3_pkg::OUT_COL_W-1:0]   m_out_col,
    input logic [tnc3_pkg::PIX_W-1:0]       m_out_value,
    input logic                             m_replaced
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_row) && $stable(m_out_col)
            && $stable(m_out_value) && $stable(m_replaced))
        else $error("result word changed while stalled");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // an empty output side never blocks the input
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with output empty");

    // a fresh result always follows an accepted pixel through the window stage
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without matching pixel");

    // interior rows only
    a_row_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_row != '0)
        else $error("border row emitted");

endmodule

bind threshold_noise_cleaning_3x3_unit tnc3_checker u_tnc3_checker (.*);

// File: verif/threshold_noise_cleaning_3x3_unit_test.sv
// ---------------------------------------------------------------------------
// threshold_noise_cleaning_3x3_unit_test
// Streams raster frames through the 3x3 noise cleaner and checks every
// interior result against an in-bench window predictor, across threshold
// and frame geometry settings, with random gaps on both channels.
// ---------------------------------------------------------------------------
module threshold_noise_cleaning_3x3_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tnc3_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int TOTAL_PIXELS  = 1150;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LIMIT_NS      = 15_000_000;
    localparam int MAX_PRINTS    = 40;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic [PIX_W-1:0]     value;
        logic                 replaced;
    } cleaned_t;

    typedef enum {
        PAT_NOISY,
        PAT_RANDOM,
        PAT_EXTREME
    } pattern_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel   = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [ROW_W-1:0]      m_out_row;
    logic [OUT_COL_W-1:0]  m_out_col;
    logic [PIX_W-1:0]      m_out_value;
    logic                  m_replaced;

    // predictor state
    logic [PIX_W-1:0] older_row [MAX_W];
    logic [PIX_W-1:0] newer_row [MAX_W];
    logic [PIX_W-1:0] win [9];
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;
    logic [THR_W-1:0] thr_shadow    = THRESHOLD_RST;
    logic [FW_W-1:0]  width_shadow  = FRAME_WIDTH_RST;
    logic [FH_W-1:0]  height_shadow = FRAME_HEIGHT_RST;

    cleaned_t         cleaned_due [$];
    logic [PIX_W-1:0] pending_pixels [$];

    int unsigned pixels_sent = 0;
    int          error_count = 0;
    bit          idle_on     = 1'b1;
    int          gap_left    = 0;
    int          ready_wait  = 0;
    int          ready_draw  = 0;
    int          hold_left   = 0;

    threshold_noise_cleaning_3x3_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_out_value (m_out_value),
        .m_replaced  (m_replaced)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int unsigned active_width();
        if (width_shadow < MIN_DIM) return MIN_DIM;
        if (width_shadow > MAX_W) return MAX_W;
        return width_shadow;
    endfunction

    function automatic int unsigned active_height();
        if (height_shadow < MIN_DIM) return MIN_DIM;
        return height_shadow;
    endfunction

    // pixels left to finish the current frame
    function automatic int unsigned frame_rest();
        if (col_pos == 0 && row_pos == 0) return 0;
        return (active_height() - row_pos) * active_width() - col_pos;
    endfunction

    function automatic int draw_wait();
        return idle_on ? int'($urandom_range(0, 9)) : 0;
    endfunction

    // slide the window by one pixel and queue the cleaned center if interior
    task automatic clean_next_pixel(input logic [PIX_W-1:0] px);
        int unsigned c, r, sum, avg, ctr, diff;
        int k;
        cleaned_t res;
        c = col_pos % MAX_W;
        r = row_pos;
        for (k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = older_row[c];
        win[5] = newer_row[c];
        win[8] = px;
        older_row[c] = newer_row[c];
        newer_row[c] = px;
        if (r >= 2 && c >= 2) begin
            sum = 0;
            for (k = 0; k < 9; k++) begin
                if (k != 4) sum += win[k];
            end
            avg  = sum >> 3;
            ctr  = win[4];
            diff = (ctr > avg) ? ctr - avg : avg - ctr;
            res.replaced = (diff > thr_shadow);
            res.row      = ROW_W'(r - 1);
            res.col      = OUT_COL_W'(c - 1);
            res.value    = PIX_W'(res.replaced ? avg : ctr);
            cleaned_due.insert(cleaned_due.size(), res);
        end
        if (c + 1 >= active_width()) begin
            col_pos = 0;
            row_pos = (r + 1 >= active_height()) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic check_cleaned();
        cleaned_t want;
        if (cleaned_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word row %0d col %0d",
                                      m_out_row, m_out_col));
            return;
        end
        want = cleaned_due.pop_front();
        if (m_out_row !== want.row)
            report_mismatch($sformatf("row %0d, want %0d", m_out_row, want.row));
        if (m_out_col !== want.col)
            report_mismatch($sformatf("col %0d, want %0d", m_out_col, want.col));
        if (m_out_value !== want.value)
            report_mismatch($sformatf("value %0d, want %0d at (%0d,%0d)",
                                      m_out_value, want.value, want.row, want.col));
        if (m_replaced !== want.replaced)
            report_mismatch($sformatf("replaced %0b, want %0b at (%0d,%0d)",
                                      m_replaced, want.replaced, want.row, want.col));
    endtask

    // pixel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) clean_next_pixel(s_pixel);
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    s_valid  <= 1'b1;
                    s_pixel  <= pending_pixels.pop_front();
                    gap_left <= draw_wait();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and ready pacing
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_wait <= 0;
        end else begin
            if (m_valid && m_ready) check_cleaned();
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (m_valid && m_ready) begin
                ready_draw = draw_wait();
                ready_wait <= ready_draw;
                m_ready    <= (ready_draw == 0);
            end else if (ready_wait > 0) begin
                ready_wait <= ready_wait - 1;
                m_ready    <= (ready_wait == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // wait until every word is out, then let in-flight border pixels drain
    task automatic settle();
        while (pending_pixels.size() != 0 || s_valid || cleaned_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_THRESHOLD:    thr_shadow    = val[THR_W-1:0];
            CFG_FRAME_WIDTH:  width_shadow  = val[FW_W-1:0];
            CFG_FRAME_HEIGHT: height_shadow = val[FH_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic add_pixels(input pattern_t pat, input int unsigned count);
        int unsigned base, i;
        logic [PIX_W-1:0] px;
        base = $urandom_range(30, 225);
        for (i = 0; i < count; i++) begin
            case (pat)
                PAT_RANDOM:  px = PIX_W'($urandom_range(0, 255));
                PAT_EXTREME: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: begin
                    // smooth background with impulse noise
                    if ($urandom_range(0, 7) == 0)
                        px = $urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 255))
                           : ($urandom_range(0, 1) ? 8'hFF : 8'h00);
                    else
                        px = PIX_W'(base + $urandom_range(0, 20) - 10);
                    if ($urandom_range(0, 63) == 0) base = $urandom_range(30, 225);
                end
            endcase
            pending_pixels.insert(pending_pixels.size(), px);
        end
        pixels_sent += count;
    endtask

    // one 3x3 frame: top-left corner, rim elsewhere, chosen center
    task automatic add_3x3(input logic [PIX_W-1:0] corner_v, rim_v, ctr_v);
        int i;
        for (i = 0; i < 9; i++)
            pending_pixels.insert(pending_pixels.size(),
                                  i == 0 ? corner_v : (i == 4 ? ctr_v : rim_v));
        pixels_sent += 9;
    endtask

    // geometry only changes at frame start, so line stores never read stale columns
    task automatic new_geometry(input logic [CFG_DATA_W-1:0] w_val, h_val,
                                input pattern_t pat);
        settle();
        if (frame_rest() != 0) begin
            add_pixels(pat, frame_rest());
            settle();
        end
        write_reg(CFG_FRAME_WIDTH, w_val);
        write_reg(CFG_FRAME_HEIGHT, h_val);
    endtask

    initial begin
        int i;
        int unsigned w, h, n, thr;
        pattern_t pat;
        for (i = 0; i < MAX_W; i++) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        for (i = 0; i < 9; i++) win[i] = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // width and height below minimum both clamp to 3
        new_geometry(16'd0, 16'd1, PAT_RANDOM);
        write_reg(CFG_THRESHOLD, 16'd0);
        add_3x3(8'hFF, 8'hFF, 8'h00);
        settle();
        // difference of 255 never exceeds the top threshold
        write_reg(CFG_THRESHOLD, 16'h00FF);
        add_3x3(8'h00, 8'h00, 8'hFF);
        settle();
        // neighbor sum of 7 floors to 0, difference equal to threshold passes
        write_reg(CFG_THRESHOLD, 16'd200);
        add_3x3(8'd7, 8'h00, 8'd200);

        // output held off while input streams, so the pipe backs up
        new_geometry(16'd16, 16'd6, PAT_NOISY);
        write_reg(CFG_THRESHOLD, 16'd20);
        idle_on = 1'b0;
        add_pixels(PAT_NOISY, 16 * 6);
        hold_left = 300;
        settle();
        idle_on = 1'b1;

        while (pixels_sent < TOTAL_PIXELS) begin
            settle();
            idle_on = ($urandom_range(0, 3) != 0);
            pat = pattern_t'($urandom_range(0, 2));
            if ($urandom_range(0, 2) == 0 && frame_rest() < TOTAL_PIXELS - pixels_sent) begin
                case ($urandom_range(0, 7))
                    0:       w = $urandom_range(0, 2);
                    1:       w = $urandom_range(25, 120);
                    default: w = $urandom_range(3, 24);
                endcase
                h = (w > 24) ? $urandom_range(3, 4) : $urandom_range(0, 8);
                new_geometry(CFG_DATA_W'(w), CFG_DATA_W'(h), pat);
            end
            case ($urandom_range(0, 5))
                0:       thr = 0;
                1:       thr = 255;
                2:       thr = $urandom_range(0, 255);
                default: thr = $urandom_range(0, 48);
            endcase
            write_reg(CFG_THRESHOLD, {8'($urandom), 8'(thr)});
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, 2 * active_width() * active_height());
            else
                n = $urandom_range(1, 2) * active_width() * active_height();
            if (n > TOTAL_PIXELS - pixels_sent) n = TOTAL_PIXELS - pixels_sent;
            if ($urandom_range(0, 9) == 0) hold_left = $urandom_range(20, 120);
            add_pixels(pat, n);
        end

        settle();
        if (error_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("%0t ns: timeout, %0d words still expected", $time, cleaned_due.size());
        $display("FAILURE");
        $finish;
    end

endmodule
